// ----- sv/rnst_pkg.sv -----
// ----------------------------------------------------------------------------
// rnst_pkg: shared definitions for the ranked name and score table
// Sizes, operation and status codes, and a small helper for count outputs.
// ----------------------------------------------------------------------------
package rnst_pkg;

    localparam int CAPACITY   = 128;
    localparam int NAME_BYTES = 19;
    localparam int SCORE_BITS = 16;

    localparam int KEY_W   = 8 * NAME_BYTES;
    localparam int SC_W    = (SCORE_BITS < 16) ? SCORE_BITS : 16;
    localparam int ENTRY_W = KEY_W + SC_W;
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_DELETED   = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    function automatic logic [7:0] sat8(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'd255) ? 8'd255 : w[7:0];
    endfunction

endpackage

// ----- sv/rnst_ram.sv -----
// ----------------------------------------------------------------------------
// rnst_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module rnst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- sv/ranked_name_score_table.sv -----
// ----------------------------------------------------------------------------
// ranked_name_score_table: keyed name table with competition rank
// Stores unique name keys with scores; supports insert, search and delete.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge with start high and busy low. Each item
// gives one result, shown on the o_ result ports for one cycle with o_valid
// high; the receiver cannot stall it.
// Keys and scores live in one RAM with a registered read. An item first sweeps
// every entry to find the key and the first free slot, then decides and
// writes in one state. Successful inserts and search hits sweep the RAM a
// second time to count higher scores; busy falls as the strobe rises, so the
// next item may be taken in the strobe cycle. Both sweeps go through the
// single RAM read port, and no new item is taken until the last is done.
// Reset clears all valid bits and the entry count; the RAM
// contents need no clearing, since only valid entries are ever used.
// ----------------------------------------------------------------------------
module ranked_name_score_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_name_lo,
    input  logic [63:0] i_name_mid,
    input  logic [23:0] i_name_hi,
    input  logic [15:0] i_score,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_score_out,
    output logic [7:0]  o_rank_out,
    output logic [7:0]  o_entry_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_DECIDE,
        S_RANK
    } t_state;

    t_state                          r_state;
    logic [rnst_pkg::CAPACITY-1:0]   r_valid;
    logic [rnst_pkg::CNT_W-1:0]      r_count;
    logic [1:0]                      r_op;
    logic [rnst_pkg::KEY_W-1:0]      r_key;
    logic [rnst_pkg::SC_W-1:0]       r_sc;
    logic [rnst_pkg::SC_W-1:0]       r_tgt;
    logic [rnst_pkg::CNT_W-1:0]      r_cnt;
    logic                            r_pend;
    logic [rnst_pkg::IDX_W-1:0]      r_pidx;
    logic                            r_match_hit;
    logic [rnst_pkg::IDX_W-1:0]      r_match_idx;
    logic [rnst_pkg::SC_W-1:0]       r_match_sc;
    logic                            r_free_hit;
    logic [rnst_pkg::IDX_W-1:0]      r_free_idx;
    logic [rnst_pkg::CNT_W-1:0]      r_rank;

    logic                            ram_we;
    logic [rnst_pkg::ENTRY_W-1:0]    ram_rdata;
    logic [rnst_pkg::KEY_W-1:0]      rd_key;
    logic [rnst_pkg::SC_W-1:0]       rd_sc;
    logic                            rd_valid;
    logic                            last_elem;
    logic [rnst_pkg::CNT_W-1:0]      n_rank;
    logic [rnst_pkg::KEY_W-1:0]      in_key;

    assign in_key    = rnst_pkg::KEY_W'({i_name_hi, i_name_mid, i_name_lo});
    assign rd_key    = ram_rdata[rnst_pkg::ENTRY_W-1:rnst_pkg::SC_W];
    assign rd_sc     = ram_rdata[rnst_pkg::SC_W-1:0];
    assign rd_valid  = r_valid[r_pidx];
    assign last_elem = r_pend && (r_pidx == rnst_pkg::IDX_W'(rnst_pkg::CAPACITY - 1));
    assign busy      = (r_state != S_IDLE);

    always_comb begin
        n_rank = r_rank;
        if (r_pend && rd_valid && (rd_sc > r_tgt)) begin
            n_rank = r_rank + rnst_pkg::CNT_W'(1);
        end
        ram_we = (r_state == S_DECIDE) && (r_op == rnst_pkg::OP_INSERT)
                 && !r_match_hit && r_free_hit;
    end

    rnst_ram #(
        .WIDTH (rnst_pkg::ENTRY_W),
        .DEPTH (rnst_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata ({r_key, r_sc}),
        .i_raddr (r_cnt[rnst_pkg::IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (r_state == S_FIND || r_state == S_RANK) begin
                r_pend <= (r_cnt < rnst_pkg::CNT_W'(rnst_pkg::CAPACITY));
                r_pidx <= r_cnt[rnst_pkg::IDX_W-1:0];
                if (r_cnt < rnst_pkg::CNT_W'(rnst_pkg::CAPACITY)) begin
                    r_cnt <= r_cnt + rnst_pkg::CNT_W'(1);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op        <= i_op;
                        r_key       <= in_key;
                        r_sc        <= i_score[rnst_pkg::SC_W-1:0];
                        r_match_hit <= 1'b0;
                        r_free_hit  <= 1'b0;
                        r_cnt       <= '0;
                        r_pend      <= 1'b0;
                        r_state     <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (r_pend) begin
                        if (rd_valid && (rd_key == r_key) && !r_match_hit) begin
                            r_match_hit <= 1'b1;
                            r_match_idx <= r_pidx;
                            r_match_sc  <= rd_sc;
                        end
                        if (!rd_valid && !r_free_hit) begin
                            r_free_hit <= 1'b1;
                            r_free_idx <= r_pidx;
                        end
                    end
                    if (last_elem) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_cnt      <= '0;
                    r_pend     <= 1'b0;
                    r_rank     <= rnst_pkg::CNT_W'(1);
                    o_score_out <= '0;
                    o_rank_out <= '0;
                    o_entry_count <= rnst_pkg::sat8(r_count);
                    o_status   <= rnst_pkg::ST_NOT_FOUND;
                    r_state    <= S_IDLE;
                    o_valid    <= 1'b1;
                    case (r_op)
                        rnst_pkg::OP_INSERT: begin
                            if (r_match_hit) begin
                                o_status <= rnst_pkg::ST_DUPLICATE;
                            end else if (!r_free_hit) begin
                                o_status <= rnst_pkg::ST_FULL;
                            end else begin
                                r_valid[r_free_idx] <= 1'b1;
                                r_count     <= r_count + rnst_pkg::CNT_W'(1);
                                r_tgt       <= r_sc;
                                o_status    <= rnst_pkg::ST_INSERTED;
                                o_score_out <= 16'(r_sc);
                                o_valid     <= 1'b0;
                                r_state     <= S_RANK;
                            end
                        end
                        rnst_pkg::OP_SEARCH: begin
                            if (r_match_hit) begin
                                r_tgt       <= r_match_sc;
                                o_status    <= rnst_pkg::ST_FOUND;
                                o_score_out <= 16'(r_match_sc);
                                o_valid     <= 1'b0;
                                r_state     <= S_RANK;
                            end
                        end
                        rnst_pkg::OP_DELETE: begin
                            if (r_count == '0) begin
                                o_status <= rnst_pkg::ST_EMPTY;
                            end else if (r_match_hit) begin
                                r_valid[r_match_idx] <= 1'b0;
                                r_count       <= r_count - rnst_pkg::CNT_W'(1);
                                o_status      <= rnst_pkg::ST_DELETED;
                                o_score_out   <= 16'(r_match_sc);
                                o_entry_count <= rnst_pkg::sat8(
                                    r_count - rnst_pkg::CNT_W'(1));
                            end
                        end
                        default: begin
                            o_status <= rnst_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
                S_RANK: begin
                    r_rank <= n_rank;
                    if (last_elem) begin
                        o_rank_out    <= rnst_pkg::sat8(n_rank);
                        o_entry_count <= rnst_pkg::sat8(r_count);
                        o_valid       <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("Entry count disagrees with the valid bits.");

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("Result strobe while an item is still at work.");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted item did not raise busy.");

    a_insert_has_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == rnst_pkg::ST_INSERTED)) |-> (o_rank_out != 8'd0))
        else $error("Inserted item reported without a rank.");

    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("Result strobe lasted more than one cycle.");
`endif

endmodule

// ----- bench/tb_ranked_name_score_table.sv -----
// ----------------------------------------------------------------------------
// tb_ranked_name_score_table: self-checking bench for the ranked name table
// Items go in through the start and busy handshake. A behavioral copy of the
// table in the bench predicts every result, and each strobed result is
// compared field by field with the oldest prediction. Directed tests cover
// the empty table, key and score extremes and the duplicate, full and empty
// checks. Random traffic then fills and drains the table with idle gaps.
// ----------------------------------------------------------------------------
module tb_ranked_name_score_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int SETTLE_CYCLES = 2 * rnst_pkg::CAPACITY + 8;
    localparam int POOL_SIZE     = 200;
    localparam int RANDOM_ITEMS  = 660;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] score;
        logic [7:0]  rank;
        logic [7:0]  count;
    } t_reply;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic [1:0]  i_op          = rnst_pkg::OP_INSERT;
    logic [63:0] i_name_lo     = '0;
    logic [63:0] i_name_mid    = '0;
    logic [23:0] i_name_hi     = '0;
    logic [15:0] i_score       = '0;
    logic        busy;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [15:0] o_score_out;
    logic [7:0]  o_rank_out;
    logic [7:0]  o_entry_count;

    bit                         tbl_valid [rnst_pkg::CAPACITY];
    logic [rnst_pkg::KEY_W-1:0] tbl_key   [rnst_pkg::CAPACITY];
    logic [15:0]                tbl_score [rnst_pkg::CAPACITY];
    int                         tbl_total;
    int                         peak_total;

    t_reply                     pending_replies [$];
    logic [rnst_pkg::KEY_W-1:0] name_pool [POOL_SIZE];
    int                         status_seen [8];
    int                         items_sent;
    int                         replies_checked;
    int                         fail_count;
    bit                         idle_on = 1'b1;
    int unsigned                cycle_count;

    ranked_name_score_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_name_lo     (i_name_lo),
        .i_name_mid    (i_name_mid),
        .i_name_hi     (i_name_hi),
        .i_score       (i_score),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_score_out   (o_score_out),
        .o_rank_out    (o_rank_out),
        .o_entry_count (o_entry_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_replies.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] clamp_count(input int v);
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic int count_higher(input logic [15:0] s);
        int n;
        n = 0;
        for (int i = 0; i < rnst_pkg::CAPACITY; i++) begin
            if (tbl_valid[i] && tbl_score[i] > s) begin
                n++;
            end
        end
        return n;
    endfunction

    function automatic t_reply apply_table_op(input logic [1:0] op,
                                              input logic [rnst_pkg::KEY_W-1:0] name,
                                              input logic [15:0] score_in);
        int          hit;
        int          slot;
        logic [15:0] sc;
        t_reply      r;
        hit = -1;
        slot = -1;
        sc = 16'(64'(score_in) & ((64'd1 << rnst_pkg::SCORE_BITS) - 64'd1));
        r.status = rnst_pkg::ST_NOT_FOUND;
        r.score = '0;
        r.rank = '0;
        for (int i = 0; i < rnst_pkg::CAPACITY; i++) begin
            if (tbl_valid[i] && tbl_key[i] == name && hit < 0) begin
                hit = i;
            end
            if (!tbl_valid[i] && slot < 0) begin
                slot = i;
            end
        end
        case (op)
            rnst_pkg::OP_INSERT: begin
                if (hit >= 0) begin
                    r.status = rnst_pkg::ST_DUPLICATE;
                end else if (slot < 0) begin
                    r.status = rnst_pkg::ST_FULL;
                end else begin
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot] = name;
                    tbl_score[slot] = sc;
                    tbl_total++;
                    r.status = rnst_pkg::ST_INSERTED;
                    r.score = sc;
                    r.rank = clamp_count(1 + count_higher(sc));
                end
            end
            rnst_pkg::OP_SEARCH: begin
                if (hit >= 0) begin
                    r.status = rnst_pkg::ST_FOUND;
                    r.score = tbl_score[hit];
                    r.rank = clamp_count(1 + count_higher(tbl_score[hit]));
                end
            end
            rnst_pkg::OP_DELETE: begin
                if (tbl_total == 0) begin
                    r.status = rnst_pkg::ST_EMPTY;
                end else if (hit >= 0) begin
                    r.status = rnst_pkg::ST_DELETED;
                    r.score = tbl_score[hit];
                    tbl_valid[hit] = 1'b0;
                    tbl_total--;
                end
            end
            default: begin
            end
        endcase
        r.count = clamp_count(tbl_total);
        status_seen[r.status]++;
        if (tbl_total > peak_total) begin
            peak_total = tbl_total;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 94) begin
            return $urandom_range(1, 4);
        end else if (r < 97) begin
            return $urandom_range(5, 60);
        end
        return $urandom_range(61, 300);
    endfunction

    function automatic logic [rnst_pkg::KEY_W-1:0] random_name();
        logic [159:0] raw;
        int           a;
        int           b;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        if ($urandom_range(0, 3) == 0) begin
            a = $urandom_range(0, rnst_pkg::NAME_BYTES - 1);
            b = $urandom_range(a, rnst_pkg::NAME_BYTES - 1);
            for (int k = a; k <= b; k++) begin
                raw[8*k +: 8] = 8'h00;
            end
        end
        return rnst_pkg::KEY_W'(raw);
    endfunction

    function automatic logic [15:0] random_score();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return 16'($urandom_range(0, 15));
        end else if (r == 4) begin
            return 16'h0000;
        end else if (r == 5) begin
            return 16'hFFFF;
        end
        return 16'($urandom());
    endfunction

    function automatic logic [rnst_pkg::KEY_W-1:0] present_name();
        int i;
        if (tbl_total == 0) begin
            return name_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        do begin
            i = $urandom_range(0, rnst_pkg::CAPACITY - 1);
        end while (!tbl_valid[i]);
        return tbl_key[i];
    endfunction

    task automatic log_failure(input string text);
        if (fail_count < 10) begin
            $display("%0t: %s", $realtime, text);
        end
        fail_count++;
    endtask

    task automatic send_op(input logic [1:0] op, input logic [rnst_pkg::KEY_W-1:0] name,
                           input logic [15:0] score_in);
        int           gap;
        logic [151:0] full_name;
        gap = pick_gap();
        full_name = 152'(name);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_op <= op;
        i_name_lo <= full_name[63:0];
        i_name_mid <= full_name[127:64];
        i_name_hi <= full_name[151:128];
        i_score <= score_in;
        start <= 1'b1;
        do begin
            @(negedge i_clk);
        end while (busy !== 1'b0);
        @(posedge i_clk);
        pending_replies.push_back(apply_table_op(op, name, score_in));
        items_sent++;
    endtask

    task automatic wait_for_replies();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_replies.size() != 0);
    endtask

    always @(posedge i_clk) begin : check_replies
        t_reply got;
        t_reply want;
        if (i_rst_n && o_valid !== 1'b0) begin
            got.status = o_status;
            got.score = o_score_out;
            got.rank = o_rank_out;
            got.count = o_entry_count;
            if (pending_replies.size() == 0) begin
                log_failure($sformatf(
                    "Unexpected result: status %0d score %0d rank %0d count %0d",
                    got.status, got.score, got.rank, got.count));
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status || got.score !== want.score ||
                    got.rank !== want.rank || got.count !== want.count) begin
                    log_failure($sformatf({
                        "Result %0d: expected status %0d score %0d rank %0d count %0d, ",
                        "got status %0d score %0d rank %0d count %0d"},
                        replies_checked, want.status, want.score, want.rank,
                        want.count, got.status, got.score, got.rank, got.count));
                end
                replies_checked++;
            end
        end
    end

    task automatic test_empty_table();
        send_op(rnst_pkg::OP_DELETE, '0, 16'h1234);
        send_op(rnst_pkg::OP_SEARCH, '0, 16'h0000);
        send_op(OP_UNUSED, '1, 16'hFFFF);
        send_op(rnst_pkg::OP_DELETE, '1, 16'h0000);
    endtask

    task automatic test_directed_cases();
        logic [rnst_pkg::KEY_W-1:0] name_a;
        logic [rnst_pkg::KEY_W-1:0] name_gap;
        logic [rnst_pkg::KEY_W-1:0] name_top;
        name_a = rnst_pkg::KEY_W'(64'h41);
        name_gap = rnst_pkg::KEY_W'(64'h0042_0041);
        name_top = name_a | (rnst_pkg::KEY_W'(1) << (rnst_pkg::KEY_W - 1));
        send_op(rnst_pkg::OP_INSERT, '0, 16'h0000);
        send_op(rnst_pkg::OP_INSERT, '1, 16'hFFFF);
        send_op(rnst_pkg::OP_SEARCH, '0, 16'hABCD);
        send_op(rnst_pkg::OP_INSERT, '0, 16'h7777);
        send_op(rnst_pkg::OP_INSERT, name_gap, 16'hFFFF);
        send_op(rnst_pkg::OP_INSERT, name_a, 16'h8000);
        send_op(rnst_pkg::OP_SEARCH, name_a, 16'h0000);
        send_op(rnst_pkg::OP_SEARCH, name_gap, 16'h0000);
        send_op(rnst_pkg::OP_SEARCH, name_top, 16'h0000);
        send_op(rnst_pkg::OP_INSERT, name_top, 16'h0001);
        send_op(OP_UNUSED, name_a, 16'h5555);
        send_op(OP_UNUSED, '1, 16'hFFFF);
        send_op(rnst_pkg::OP_DELETE, name_a, 16'hFFFF);
        send_op(rnst_pkg::OP_DELETE, name_a, 16'h0000);
        send_op(rnst_pkg::OP_SEARCH, '1, 16'h0000);
        send_op(rnst_pkg::OP_DELETE, '1, 16'h0000);
        send_op(rnst_pkg::OP_DELETE, '0, 16'h0000);
        send_op(rnst_pkg::OP_DELETE, name_gap, 16'h0000);
        send_op(rnst_pkg::OP_DELETE, name_top, 16'h0000);
        send_op(rnst_pkg::OP_DELETE, name_top, 16'h0000);
    endtask

    task automatic test_fill_to_capacity();
        logic [rnst_pkg::KEY_W-1:0] held;
        idle_on = 1'b0;
        while (tbl_total < rnst_pkg::CAPACITY) begin
            send_op(rnst_pkg::OP_INSERT, random_name(), random_score());
        end
        idle_on = 1'b1;
        held = tbl_key[$urandom_range(0, rnst_pkg::CAPACITY - 1)];
        send_op(rnst_pkg::OP_INSERT, held, random_score());
        send_op(rnst_pkg::OP_INSERT, random_name(), random_score());
        send_op(rnst_pkg::OP_SEARCH, held, random_score());
        send_op(rnst_pkg::OP_DELETE, held, random_score());
        send_op(rnst_pkg::OP_INSERT, random_name(), random_score());
        send_op(rnst_pkg::OP_INSERT, random_name(), random_score());
    endtask

    task automatic test_drain_table();
        wait_for_replies();
        for (int i = 0; i < rnst_pkg::CAPACITY; i++) begin
            if (tbl_valid[i]) begin
                send_op(rnst_pkg::OP_DELETE, tbl_key[i], random_score());
            end
        end
        send_op(rnst_pkg::OP_DELETE, random_name(), random_score());
        send_op(rnst_pkg::OP_SEARCH, random_name(), random_score());
    endtask

    task automatic test_random_mix();
        logic [rnst_pkg::KEY_W-1:0] name;
        logic [1:0]                 op;
        int                         pick;
        bit                         filling;
        for (int i = 0; i < POOL_SIZE; i++) begin
            name_pool[i] = random_name();
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            filling = ((n / 110) % 2) == 0;
            idle_on = ((n / 55) % 4) != 3;
            pick = $urandom_range(0, 99);
            if (filling) begin
                op = (pick < 68) ? rnst_pkg::OP_INSERT :
                     (pick < 85) ? rnst_pkg::OP_SEARCH :
                     (pick < 96) ? rnst_pkg::OP_DELETE : OP_UNUSED;
            end else begin
                op = (pick < 15) ? rnst_pkg::OP_INSERT :
                     (pick < 35) ? rnst_pkg::OP_SEARCH :
                     (pick < 95) ? rnst_pkg::OP_DELETE : OP_UNUSED;
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                name = random_name();
            end else if (op != rnst_pkg::OP_INSERT && pick < 75) begin
                name = present_name();
            end else begin
                name = name_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            send_op(op, name, random_score());
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_directed_cases();
        test_fill_to_capacity();
        test_drain_table();
        test_random_mix();
        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d items: %0d inserts, %0d duplicates, %0d full, %0d found,",
                 items_sent, status_seen[rnst_pkg::ST_INSERTED],
                 status_seen[rnst_pkg::ST_DUPLICATE], status_seen[rnst_pkg::ST_FULL],
                 status_seen[rnst_pkg::ST_FOUND]);
        $display("%0d misses, %0d deletes, %0d on an empty table.",
                 status_seen[rnst_pkg::ST_NOT_FOUND], status_seen[rnst_pkg::ST_DELETED],
                 status_seen[rnst_pkg::ST_EMPTY]);
        $display("Peak occupancy %0d of %0d entries; %0d results checked, %0d failures.",
                 peak_total, rnst_pkg::CAPACITY, replies_checked, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
